FILE: rtl/tmd_pkg.sv
// Shared types and constants for the timestamp minute difference unit.
// Holds field widths, calendar constants, the month table and the stage-load struct.
// No dependencies.
package tmd_pkg;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int RESULT_W = 32;

  // Internal widths
  localparam int QUOT_W    = 6;   // year / 100, at most 40
  localparam int CUM_W     = 9;   // days before a month, at most 365
  localparam int HM_W      = 11;  // hour * 60 + minute, at most 1923
  localparam int LEAPS_W   = 11;  // leap days before a year
  localparam int DAYS_W    = 21;  // absolute day count
  localparam int PROD100_W = 25;  // year times the 1/100 reciprocal

  // Number of valid stages, output register included
  localparam int NUM_STAGES = 4;

  // Calendar constants
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [10:0] MIN_PER_DAY    = 11'd1440;
  localparam logic [5:0]  MIN_PER_HOUR   = 6'd60;
  localparam logic [6:0]  YEARS_PER_CENT = 7'd100;

  // floor(x / 100) == (x * RECIP100) >> RECIP_SHIFT for any 12-bit x
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Saturation bounds of the result
  localparam logic signed [RESULT_W:0] RESULT_MAX = 33'sd1600000000;
  localparam logic signed [RESULT_W:0] RESULT_MIN = -33'sd1600000000;

  // Month code for March; months from here on follow February
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;

  // Load enables of the pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic out;
  } tmd_adv_t;

  // Days in all months before the given month of a common year.
  // Month zero counts no months, months above twelve count the whole year.
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [CUM_W-1:0] days;
    case (month)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd365;
    endcase
    return days;
  endfunction

endpackage

FILE: rtl/tmd_pipe_ctrl.sv
// Valid tracking and load control for the four-stage pipeline.
// Depends on tmd_pkg for the stage count and the load-enable struct.
module tmd_pipe_ctrl
  import tmd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tmd_adv_t adv_o
);

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] adv;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  // Shift valid bits along with the data; hold them where a stage is stalled
  always_comb begin
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign adv_o.s1    = adv[0];
  assign adv_o.s2    = adv[1];
  assign adv_o.s3    = adv[2];
  assign adv_o.out   = adv[3];
  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

endmodule

FILE: rtl/tmd_abs_min.sv
// Three-stage converter from one timestamp to minutes since the start of year 0.
// Depends on tmd_pkg for widths, calendar constants and the month table.
module tmd_abs_min
  import tmd_pkg::*;
(
  input  logic                clk_i,
  input  tmd_adv_t            adv_i,
  input  logic [YEAR_W-1:0]   year_i,
  input  logic [MONTH_W-1:0]  month_i,
  input  logic [DAY_W-1:0]    day_i,
  input  logic [HOUR_W-1:0]   hour_i,
  input  logic [MINUTE_W-1:0] minute_i,
  output logic [RESULT_W-1:0] minutes_o
);

  // Stage 1: reciprocal quotients, year days, month table, hour-minute sum
  logic [YEAR_W-1:0]    prev_year;
  logic [PROD100_W-1:0] prod_y;
  logic [PROD100_W-1:0] prod_p;
  logic [QUOT_W-1:0]    qy_d, qy_q;
  logic [QUOT_W-1:0]    qp_d, qp_q;
  logic [DAYS_W-1:0]    y365_d, y365_q;
  logic [CUM_W-1:0]     cum_d, cum_q;
  logic [HM_W-1:0]      hm_d, hm_q;
  logic [YEAR_W-1:0]    year_q;
  logic [YEAR_W-1:0]    prev_q;
  logic                 late_d, late_q;
  logic                 ynz_d, ynz_q;
  logic [DAY_W-1:0]     day_q;

  always_comb begin
    prev_year = year_i - YEAR_W'(1);
    prod_y    = PROD100_W'(year_i) * PROD100_W'(RECIP100);
    prod_p    = PROD100_W'(prev_year) * PROD100_W'(RECIP100);
    qy_d      = prod_y[RECIP_SHIFT +: QUOT_W];
    qp_d      = prod_p[RECIP_SHIFT +: QUOT_W];
    y365_d    = DAYS_W'(year_i) * DAYS_W'(DAYS_PER_YEAR);
    cum_d     = cum_days(month_i);
    late_d    = (month_i >= MONTH_MAR);
    ynz_d     = (year_i != '0);
    hm_d      = HM_W'(hour_i) * HM_W'(MIN_PER_HOUR) + HM_W'(minute_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      year_q <= year_i;
      prev_q <= prev_year;
      qy_q   <= qy_d;
      qp_q   <= qp_d;
      y365_q <= y365_d;
      cum_q  <= cum_d;
      late_q <= late_d;
      ynz_q  <= ynz_d;
      day_q  <= day_i;
      hm_q   <= hm_d;
    end
  end

  // Stage 2: leap test, leap days before the year, day count
  logic                is4;
  logic                is100;
  logic                is400;
  logic                leap;
  logic [LEAPS_W-1:0]  leaps;
  logic [DAYS_W-1:0]   days_d, days_q;
  logic [HM_W-1:0]     hm2_q;

  always_comb begin
    is4   = (year_q[1:0] == 2'd0);
    is100 = ((YEAR_W'(qy_q) * YEAR_W'(YEARS_PER_CENT)) == year_q);
    is400 = is100 && (qy_q[1:0] == 2'd0);
    leap  = (is4 && !is100) || is400;
    // year 0 is leap, so every year above 0 counts it
    leaps = ynz_q ? (LEAPS_W'(prev_q[YEAR_W-1:2]) - LEAPS_W'(qp_q)
                     + LEAPS_W'(qp_q[QUOT_W-1:2]) + LEAPS_W'(1))
                  : '0;
    days_d = y365_q + DAYS_W'(leaps) + DAYS_W'(cum_q)
           + DAYS_W'(late_q && leap) + DAYS_W'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      days_q <= days_d;
      hm2_q  <= hm_q;
    end
  end

  // Stage 3: scale days to minutes and add the time of day
  logic [RESULT_W-1:0] min_d, min_q;

  assign min_d = RESULT_W'(days_q) * RESULT_W'(MIN_PER_DAY) + RESULT_W'(hm2_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      min_q <= min_d;
    end
  end

  assign minutes_o = min_q;

endmodule

FILE: rtl/timestamp_minute_difference_unit.sv
// Timestamp minute difference unit: signed minutes from timestamp A to timestamp B.
// Depends on tmd_pkg, tmd_pipe_ctrl and tmd_abs_min.
//
// Input channel: in_valid_i / in_stall_o carry one beat with both timestamps
// (year, month, day, hour, minute of A and of B). Output channel:
// out_valid_o / out_stall_i carry one beat with minutes_between_o, two's
// complement, saturated to +/-1600000000.
// An accepted input beat runs through three stages that convert each
// timestamp to absolute minutes (reciprocal quotients and month table,
// leap and day count, multiply by 1440), and the output register then
// takes the difference and saturates it and presents the output beat.
// Throughput is one beat per cycle while the receiver does not stall; both
// timestamps run through their own converter side by side.
// When the receiver stalls, the output beat holds and stages behind it fill
// their empty slots; in_stall_o rises only once every stage holds a beat.
// Reset clears all valid bits; the pipeline is empty and ready afterward.
module timestamp_minute_difference_unit
  import tmd_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [YEAR_W-1:0]          year_a_i,
  input  logic [MONTH_W-1:0]         month_a_i,
  input  logic [DAY_W-1:0]           day_a_i,
  input  logic [HOUR_W-1:0]          hour_a_i,
  input  logic [MINUTE_W-1:0]        minute_a_i,
  input  logic [YEAR_W-1:0]          year_b_i,
  input  logic [MONTH_W-1:0]         month_b_i,
  input  logic [DAY_W-1:0]           day_b_i,
  input  logic [HOUR_W-1:0]          hour_b_i,
  input  logic [MINUTE_W-1:0]        minute_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RESULT_W-1:0] minutes_between_o
);

  tmd_adv_t            adv;
  logic [RESULT_W-1:0] min_a;
  logic [RESULT_W-1:0] min_b;

  tmd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .adv_o       (adv)
  );

  tmd_abs_min u_abs_a (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (year_a_i),
    .month_i   (month_a_i),
    .day_i     (day_a_i),
    .hour_i    (hour_a_i),
    .minute_i  (minute_a_i),
    .minutes_o (min_a)
  );

  tmd_abs_min u_abs_b (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (year_b_i),
    .month_i   (month_b_i),
    .day_i     (day_b_i),
    .hour_i    (hour_b_i),
    .minute_i  (minute_b_i),
    .minutes_o (min_b)
  );

  // Subtract and clamp to the result range
  logic signed [RESULT_W:0]   diff;
  logic signed [RESULT_W:0]   sat;
  logic signed [RESULT_W-1:0] result_d, result_q;

  always_comb begin
    diff = $signed({1'b0, min_b}) - $signed({1'b0, min_a});
    if (diff > RESULT_MAX) begin
      sat = RESULT_MAX;
    end else if (diff < RESULT_MIN) begin
      sat = RESULT_MIN;
    end else begin
      sat = diff;
    end
    result_d = sat[RESULT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv.out) begin
      result_q <= result_d;
    end
  end

  assign minutes_between_o = result_q;

endmodule

FILE: rtl/tmd_checker.sv
// Port-level checks for timestamp_minute_difference_unit, attached by bind.
// Depends on tmd_pkg for widths and the result bounds.
module tmd_checker
  import tmd_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [YEAR_W-1:0]          year_a_i,
  input logic [MONTH_W-1:0]         month_a_i,
  input logic [DAY_W-1:0]           day_a_i,
  input logic [HOUR_W-1:0]          hour_a_i,
  input logic [MINUTE_W-1:0]        minute_a_i,
  input logic [YEAR_W-1:0]          year_b_i,
  input logic [MONTH_W-1:0]         month_b_i,
  input logic [DAY_W-1:0]           day_b_i,
  input logic [HOUR_W-1:0]          hour_b_i,
  input logic [MINUTE_W-1:0]        minute_b_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [RESULT_W-1:0] minutes_between_o
);

  logic same_ts;
  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;
  assign same_ts = (year_a_i == year_b_i) && (month_a_i == month_b_i)
                && (day_a_i == day_b_i) && (hour_a_i == hour_b_i)
                && (minute_a_i == minute_b_i);

  // A stalled output beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  // A stalled output beat keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(minutes_between_o))
    else $error("output beat changed under stall");

  // Every result lies inside the saturation bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed({minutes_between_o[RESULT_W-1], minutes_between_o})
                       <= RESULT_MAX)
                 && ($signed({minutes_between_o[RESULT_W-1], minutes_between_o})
                       >= RESULT_MIN))
    else $error("result outside saturation bounds");

  // Equal timestamps give zero once the beat has run through the stages with a free-running output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && same_ts) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o && (minutes_between_o == '0))
    else $error("equal timestamps did not give zero minutes");

endmodule

bind timestamp_minute_difference_unit tmd_checker u_tmd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .year_a_i          (year_a_i),
  .month_a_i         (month_a_i),
  .day_a_i           (day_a_i),
  .hour_a_i          (hour_a_i),
  .minute_a_i        (minute_a_i),
  .year_b_i          (year_b_i),
  .month_b_i         (month_b_i),
  .day_b_i           (day_b_i),
  .hour_b_i          (hour_b_i),
  .minute_b_i        (minute_b_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .minutes_between_o (minutes_between_o)
);
